### sv/gisq_pkg.sv
`timescale 1ns / 1ps

package gisq_pkg;

	// Command codes of the input item
	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_DONE  = 2'd2;

	// Device register addresses
	localparam logic [7:0] REG_SAMPLE_DIV = 8'h15;
	localparam logic [7:0] REG_FILTER_FS  = 8'h16;
	localparam logic [7:0] REG_INT_SETUP  = 8'h17;
	localparam logic [7:0] REG_INT_STATUS = 8'h1A;
	localparam logic [7:0] REG_POWER      = 8'h3E;

	// Bus transfer kinds
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	// Setup step codes
	localparam logic [2:0] STEP_UNCONF = 3'd0;
	localparam logic [2:0] STEP_DIV    = 3'd1;
	localparam logic [2:0] STEP_FILTER = 3'd2;
	localparam logic [2:0] STEP_INT    = 3'd3;
	localparam logic [2:0] STEP_POWER  = 3'd4;
	localparam logic [2:0] STEP_DONE   = 3'd5;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DIV  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_SEL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INT_SETUP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_SRC   = 3'd4;
	localparam int CFG_DATA_W = 8;

	typedef struct packed {
		logic [7:0] sample_divider;
		logic [1:0] full_scale;
		logic [2:0] filter_select;
		logic [7:0] interrupt_setup;
		logic [2:0] clock_source;
	} cfg_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       xfer_ok;
		logic [7:0] status_byte;
		logic [7:0] x_high;
		logic [7:0] x_low;
		logic [7:0] y_high;
		logic [7:0] y_low;
		logic [7:0] z_high;
		logic [7:0] z_low;
	} in_item_t;

	typedef struct packed {
		logic               req_valid;
		logic               req_kind;
		logic [7:0]         req_register;
		logic [7:0]         req_data;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
		logic               data_new;
		logic               is_ready;
	} out_item_t;

endpackage

### sv/gyro_i2c_config_read_sequencer_top.sv
`timescale 1ns / 1ps

// Gyro bus sequencer: takes one command item per clock (start, read, transfer
// complete) while out_ready does not stall the output, and returns exactly one
// result item for each, carrying the bus request to issue, the latched x/y/z
// rates and the ready flag. An item is held in the input register, goes
// through the step logic that updates the sequencer state, and lands in the
// output register. The single step stage passes one item per cycle while the
// output register can take it; while a result waits on out_ready, the input
// side accepts only until the input register is full.
// Configuration writes take effect on the next item.
module gyro_i2c_config_read_sequencer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  gisq_pkg::in_item_t             in_item,
	output logic                           out_valid,
	input  logic                           out_ready,
	output gisq_pkg::out_item_t            out_item,
	input  logic                           cfg_we,
	input  logic [gisq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gisq_pkg::CFG_DATA_W-1:0] cfg_data
);
	import gisq_pkg::*;

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	logic      advance;
	out_item_t result;
	out_item_t out_q;
	logic      out_valid_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	gisq_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gisq_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= result;
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

### sv/gisq_cfg_regs.sv
`timescale 1ns / 1ps

module gisq_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gisq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gisq_pkg::CFG_DATA_W-1:0] cfg_data,
	output gisq_pkg::cfg_t                 cfg
);
	import gisq_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_divider  <= 8'd1;
			cfg_q.full_scale      <= 2'd3;
			cfg_q.filter_select   <= 3'd0;
			cfg_q.interrupt_setup <= 8'd1;
			cfg_q.clock_source    <= 3'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SAMPLE_DIV: cfg_q.sample_divider  <= cfg_data;
				CFG_FULL_SCALE: cfg_q.full_scale      <= cfg_data[1:0];
				CFG_FILTER_SEL: cfg_q.filter_select   <= cfg_data[2:0];
				CFG_INT_SETUP:  cfg_q.interrupt_setup <= cfg_data;
				CFG_CLOCK_SRC:  cfg_q.clock_source    <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### sv/gisq_step.sv
`timescale 1ns / 1ps

module gisq_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  gisq_pkg::in_item_t  item,
	input  gisq_pkg::cfg_t      cfg,
	output gisq_pkg::out_item_t result
);
	import gisq_pkg::*;

	logic [2:0]  step_q, step_d, step_mid;
	logic        busy_q, busy_d;
	logic        ready_q, ready_d;
	logic [15:0] rate_x_q, rate_y_q, rate_z_q;
	logic [15:0] rate_x_d, rate_y_d, rate_z_d;
	logic        do_setup;
	logic        fresh;
	logic        req_valid;
	logic        req_kind;
	logic [7:0]  req_register;
	logic [7:0]  req_data;

	always_comb begin
		step_mid     = step_q;
		busy_d       = busy_q;
		ready_d      = ready_q;
		rate_x_d     = rate_x_q;
		rate_y_d     = rate_y_q;
		rate_z_d     = rate_z_q;
		do_setup     = 1'b0;
		fresh        = 1'b0;
		req_valid    = 1'b0;
		req_kind     = REQ_WRITE;
		req_register = 8'd0;
		req_data     = 8'd0;

		case (item.cmd)
			CMD_START: begin
				if (step_q == STEP_UNCONF) begin
					step_mid = STEP_DIV;
					do_setup = !busy_q;
				end
			end
			CMD_READ: begin
				if (ready_q && !busy_q) begin
					req_valid    = 1'b1;
					req_kind     = REQ_READ;
					req_register = REG_INT_STATUS;
					busy_d       = 1'b1;
				end
			end
			CMD_DONE: begin
				if (busy_q) begin
					busy_d = 1'b0;
					if (ready_q) begin
						if (item.xfer_ok && item.status_byte[0]) begin
							rate_x_d = {item.x_high, item.x_low};
							rate_y_d = {item.y_high, item.y_low};
							rate_z_d = {item.z_high, item.z_low};
							fresh    = 1'b1;
						end
					end else if (step_q != STEP_UNCONF) begin
						// step already points past the failed write: back up one
						if (!item.xfer_ok && step_q <= STEP_DONE)
							step_mid = step_q - 3'd1;
						do_setup = 1'b1;
					end
				end
			end
			default: ;
		endcase

		step_d = step_mid;
		if (do_setup) begin
			unique case (step_mid)
				STEP_DIV: begin
					req_valid    = 1'b1;
					req_register = REG_SAMPLE_DIV;
					req_data     = cfg.sample_divider;
				end
				STEP_FILTER: begin
					req_valid    = 1'b1;
					req_register = REG_FILTER_FS;
					req_data     = {3'd0, cfg.full_scale, cfg.filter_select};
				end
				STEP_INT: begin
					req_valid    = 1'b1;
					req_register = REG_INT_SETUP;
					req_data     = cfg.interrupt_setup;
				end
				STEP_POWER: begin
					req_valid    = 1'b1;
					req_register = REG_POWER;
					req_data     = {5'd0, cfg.clock_source};
				end
				STEP_DONE: ready_d = 1'b1;
				default: ;
			endcase
			if (req_valid) begin
				step_d = step_mid + 3'd1;
				busy_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= STEP_UNCONF;
			busy_q   <= 1'b0;
			ready_q  <= 1'b0;
			rate_x_q <= 16'd0;
			rate_y_q <= 16'd0;
			rate_z_q <= 16'd0;
		end else if (fire) begin
			step_q   <= step_d;
			busy_q   <= busy_d;
			ready_q  <= ready_d;
			rate_x_q <= rate_x_d;
			rate_y_q <= rate_y_d;
			rate_z_q <= rate_z_d;
		end
	end

	always_comb begin
		result.req_valid    = req_valid;
		result.req_kind     = req_kind;
		result.req_register = req_register;
		result.req_data     = req_data;
		result.rate_x       = rate_x_d;
		result.rate_y       = rate_y_d;
		result.rate_z       = rate_z_d;
		result.data_new     = fresh;
		result.is_ready     = ready_d;
	end

endmodule

### sv/gisq_checker.sv
`timescale 1ns / 1ps

module gisq_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input gisq_pkg::out_item_t out_item
);
	import gisq_pkg::*;

	logic seen_ready_q;

	// remember that some delivered item reported the block configured
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_ready_q <= 1'b0;
		end else if (out_valid && out_ready && out_item.is_ready) begin
			seen_ready_q <= 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	a_ready_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_ready_q |-> out_item.is_ready)
		else $error("ready flag dropped after configuration");

	a_idle_req: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.req_valid |->
		out_item.req_kind == REQ_WRITE && out_item.req_register == 8'd0 &&
		out_item.req_data == 8'd0)
		else $error("request fields set without a request");

	a_read_req: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.req_valid && out_item.req_kind == REQ_READ |->
		out_item.req_register == REG_INT_STATUS && out_item.req_data == 8'd0 &&
		out_item.is_ready)
		else $error("malformed read request");

	a_new_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.data_new |-> out_item.is_ready && !out_item.req_valid)
		else $error("new rates outside a completed read");

endmodule

bind gyro_i2c_config_read_sequencer_top gisq_checker u_gisq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
	import gisq_pkg::*;

	localparam int N_ITEMS     = 1600;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 2000;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	class sequencer_scoreboard;
		cfg_t               cfg;
		logic [2:0]         step;
		bit                 bus_busy;
		bit                 ready_flag;
		logic signed [15:0] rates [3];
		out_item_t          resp_q [$];
		int                 n_errors;

		function new();
			cfg.sample_divider  = 8'd1;
			cfg.full_scale      = 2'd3;
			cfg.filter_select   = 3'd0;
			cfg.interrupt_setup = 8'd1;
			cfg.clock_source    = 3'd1;
			step       = STEP_UNCONF;
			bus_busy   = 1'b0;
			ready_flag = 1'b0;
			foreach (rates[i]) rates[i] = '0;
			n_errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_SAMPLE_DIV: cfg.sample_divider  = val;
				CFG_FULL_SCALE: cfg.full_scale      = val[1:0];
				CFG_FILTER_SEL: cfg.filter_select   = val[2:0];
				CFG_INT_SETUP:  cfg.interrupt_setup = val;
				CFG_CLOCK_SRC:  cfg.clock_source    = val[2:0];
				default: ;
			endcase
		endfunction

		// issue the write for the current setup step, or finish the setup
		function void issue_setup(inout out_item_t r);
			logic [7:0] addr;
			logic [7:0] val;
			addr = '0;
			val  = '0;
			case (step)
				STEP_DIV: begin
					addr = REG_SAMPLE_DIV;
					val  = cfg.sample_divider;
				end
				STEP_FILTER: begin
					addr = REG_FILTER_FS;
					val  = {3'b000, cfg.full_scale, cfg.filter_select};
				end
				STEP_INT: begin
					addr = REG_INT_SETUP;
					val  = cfg.interrupt_setup;
				end
				STEP_POWER: begin
					addr = REG_POWER;
					val  = {5'b00000, cfg.clock_source};
				end
				STEP_DONE: ready_flag = 1'b1;
				default: ;
			endcase
			if (step >= STEP_DIV && step <= STEP_POWER) begin
				r.req_valid    = 1'b1;
				r.req_kind     = REQ_WRITE;
				r.req_register = addr;
				r.req_data     = val;
				bus_busy       = 1'b1;
				step           = step + 3'd1;
			end
		endfunction

		function void note_command(in_item_t it);
			out_item_t r;
			r = '0;
			case (it.cmd)
				CMD_START: begin
					if (step == STEP_UNCONF) begin
						step = STEP_DIV;
						if (!bus_busy) issue_setup(r);
					end
				end
				CMD_READ: begin
					if (ready_flag && !bus_busy) begin
						r.req_valid    = 1'b1;
						r.req_kind     = REQ_READ;
						r.req_register = REG_INT_STATUS;
						bus_busy       = 1'b1;
					end
				end
				CMD_DONE: begin
					if (bus_busy) begin
						bus_busy = 1'b0;
						if (ready_flag) begin
							if (it.xfer_ok && it.status_byte[0]) begin
								rates[0]   = {it.x_high, it.x_low};
								rates[1]   = {it.y_high, it.y_low};
								rates[2]   = {it.z_high, it.z_low};
								r.data_new = 1'b1;
							end
						end else if (step != STEP_UNCONF) begin
							// step back so a failed write goes out again
							if (!it.xfer_ok && step <= STEP_DONE) step = step - 3'd1;
							issue_setup(r);
						end
					end
				end
				default: ;
			endcase
			r.rate_x   = rates[0];
			r.rate_y   = rates[1];
			r.rate_z   = rates[2];
			r.is_ready = ready_flag;
			resp_q.push_back(r);
		endfunction

		function int pending();
			return resp_q.size();
		endfunction

		task flag_mismatch(string msg);
			n_errors++;
			if (n_errors <= 100) $display("%0t ns: mismatch: %s", $time, msg);
		endtask

		task check_response(out_item_t got);
			out_item_t want;
			if (resp_q.size() == 0) begin
				flag_mismatch("result with no command waiting");
				return;
			end
			want = resp_q.pop_front();
			if (got.req_valid !== want.req_valid)
				flag_mismatch($sformatf("req_valid got %0b want %0b",
					got.req_valid, want.req_valid));
			if (got.req_kind !== want.req_kind)
				flag_mismatch($sformatf("req_kind got %0b want %0b",
					got.req_kind, want.req_kind));
			if (got.req_register !== want.req_register)
				flag_mismatch($sformatf("req_register got %02h want %02h",
					got.req_register, want.req_register));
			if (got.req_data !== want.req_data)
				flag_mismatch($sformatf("req_data got %02h want %02h",
					got.req_data, want.req_data));
			if (got.rate_x !== want.rate_x)
				flag_mismatch($sformatf("rate_x got %0d want %0d", got.rate_x, want.rate_x));
			if (got.rate_y !== want.rate_y)
				flag_mismatch($sformatf("rate_y got %0d want %0d", got.rate_y, want.rate_y));
			if (got.rate_z !== want.rate_z)
				flag_mismatch($sformatf("rate_z got %0d want %0d", got.rate_z, want.rate_z));
			if (got.data_new !== want.data_new)
				flag_mismatch($sformatf("data_new got %0b want %0b",
					got.data_new, want.data_new));
			if (got.is_ready !== want.is_ready)
				flag_mismatch($sformatf("is_ready got %0b want %0b",
					got.is_ready, want.is_ready));
		endtask
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_item_t              in_item   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_item;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	bit calm         = 1'b0;
	bit hold_off_req = 1'b0;
	sequencer_scoreboard sb;

	gyro_i2c_config_read_sequencer_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic [47:0] rand_bytes();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[47:0];
	endfunction

	function automatic in_item_t cmd_item(logic [1:0] cmd, logic ok, logic [7:0] status,
			logic [47:0] bytes);
		in_item_t it;
		it.cmd         = cmd;
		it.xfer_ok     = ok;
		it.status_byte = status;
		{it.x_high, it.x_low, it.y_high, it.y_low, it.z_high, it.z_low} = bytes;
		return it;
	endfunction

	task automatic send_item(input in_item_t it);
		while (!calm && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_command(it);
	endtask

	// hold the sender until every result is back and the pipe is empty
	task automatic wait_all_answered();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic load_settings(input logic [5*CFG_DATA_W-1:0] vals);
		logic [CFG_IDX_W-1:0] regs [5];
		regs = '{CFG_SAMPLE_DIV, CFG_FULL_SCALE, CFG_FILTER_SEL, CFG_INT_SETUP, CFG_CLOCK_SRC};
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= vals[i*CFG_DATA_W +: CFG_DATA_W];
			@(posedge clk);
			sb.write_reg(regs[i], vals[i*CFG_DATA_W +: CFG_DATA_W]);
		end
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check_response(out_item);
	end

	initial begin : result_sink
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_ready <= calm || ($urandom_range(99) >= 27);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
			else quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		int          n_seq;
		int          n_loop;
		bit          hold_sent;
		logic [7:0]  st;
		logic [63:0] w;
		sb = new();
		n_seq     = 0;
		n_loop    = 0;
		hold_sent = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// before start: reads, stray completions and the unused code do nothing
		send_item(cmd_item(CMD_READ, 1'b1, 8'hFF, '1));
		send_item(cmd_item(CMD_DONE, 1'b1, 8'hFF, '1));
		send_item(cmd_item(CMD_UNUSED, 1'b1, 8'hFF, '1));
		send_item(cmd_item(CMD_START, 1'b0, 8'h00, '0));
		send_item(cmd_item(CMD_START, 1'b1, 8'h00, '0));
		send_item(cmd_item(CMD_READ, 1'b0, 8'h01, '0));
		send_item(cmd_item(CMD_DONE, 1'b0, 8'h00, '0));

		wait_all_answered();
		load_settings('1);
		send_item(cmd_item(CMD_DONE, 1'b0, 8'h00, '0));
		send_item(cmd_item(CMD_DONE, 1'b1, 8'h00, '0));
		send_item(cmd_item(CMD_DONE, 1'b0, 8'hFF, '1));

		wait_all_answered();
		load_settings('0);
		send_item(cmd_item(CMD_DONE, 1'b0, 8'h00, '0));
		send_item(cmd_item(CMD_DONE, 1'b1, 8'h00, '0));
		send_item(cmd_item(CMD_DONE, 1'b1, 8'h00, '0));

		wait_all_answered();
		w = {$urandom, $urandom};
		load_settings(w[39:0]);
		send_item(cmd_item(CMD_DONE, 1'b0, 8'h00, '0));
		send_item(cmd_item(CMD_DONE, 1'b1, 8'h00, '0));
		send_item(cmd_item(CMD_DONE, 1'b1, 8'h01, '1));
		send_item(cmd_item(CMD_START, 1'b1, 8'h00, '0));

		// reads: extreme rates, a failed read, status without data ready
		send_item(cmd_item(CMD_READ, 1'b0, 8'h00, '0));
		send_item(cmd_item(CMD_READ, 1'b1, 8'hFF, '1));
		send_item(cmd_item(CMD_DONE, 1'b1, 8'h01, 48'h8000_7FFF_FFFF));
		send_item(cmd_item(CMD_READ, 1'b0, 8'h00, '0));
		send_item(cmd_item(CMD_DONE, 1'b0, 8'hFF, '1));
		send_item(cmd_item(CMD_READ, 1'b0, 8'h00, '0));
		send_item(cmd_item(CMD_DONE, 1'b1, 8'hFE, 48'h0001_8001_7F00));
		send_item(cmd_item(CMD_READ, 1'b0, 8'h00, '0));
		send_item(cmd_item(CMD_DONE, 1'b1, 8'h01, '0));

		while (n_seq < N_ITEMS) begin
			calm = (n_seq >= 700 && n_seq < 1000);
			if (n_seq >= 400 && !hold_sent) begin
				// receiver stalls while the sender keeps offering
				hold_off_req = 1'b1;
				hold_sent    = 1'b1;
			end
			if (n_loop % 250 == 249) begin
				wait_all_answered();
				w = {$urandom, $urandom};
				load_settings(w[39:0]);
			end
			n_loop++;
			if ($urandom_range(99) < 85) begin
				st    = 8'($urandom);
				st[0] = ($urandom_range(99) < 70);
				send_item(cmd_item(CMD_READ, 1'($urandom), 8'($urandom), rand_bytes()));
				send_item(cmd_item(CMD_DONE, ($urandom_range(99) < 80), st, rand_bytes()));
				n_seq += 2;
			end else begin
				send_item(cmd_item(2'($urandom), 1'($urandom), 8'($urandom), rand_bytes()));
				n_seq += 1;
			end
		end
		calm = 1'b0;

		wait_all_answered();
		repeat (10) @(posedge clk);
		if (sb.n_errors == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule
